@@ design/mcct_pkg.sv @@
package mcct_pkg;

    // fixed field and register widths
    localparam int RADIUS_W = 20;
    localparam int LIMIT_W  = 40;
    localparam int TIME_W   = 32;
    localparam int RAD_SUM_W = RADIUS_W + 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_MARGIN  = 2'd0;
    localparam logic [1:0] REG_STILL   = 2'd1;
    localparam logic [1:0] REG_OVERLAP = 2'd2;

    // register reset values
    localparam logic [RADIUS_W-1:0] MARGIN_RST  = '0;
    localparam logic [LIMIT_W-1:0]  STILL_RST   = 40'd4295;
    localparam logic [LIMIT_W-1:0]  OVERLAP_RST = 40'd4295;

    // control that travels with each item down the chain
    typedef struct packed {
        logic valid;
        logic hit;
        logic need_time;
        logic saturate;
    } ctl_t;

endpackage

@@ design/moving_circle_collision_time.sv @@
// Swept-circle first-contact unit. Each item holds two circles (position, velocity,
// radius); the result says whether they touch now or later and the first contact time
// in Q16.16 seconds (0 when already touching or no hit, saturated at all ones).
// A new item is taken every cycle (busy stays low) and each result appears once, on the
// done strobe. The chain has 7 stages that form the quadratic and its discriminant, PW
// cells (PW = max(2*COORD_WIDTH + 4, 46)) that each yield one square-root bit, 2 stages
// that form the numerator and the overflow check, 32 cells that each yield one time bit,
// and one output register. Results cannot be held off: the receiver must take every done
// pulse. Configuration must be written through the APB port only while idle; the block
// itself does not enforce this.
module moving_circle_collision_time #(
    parameter int COORD_WIDTH = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mcct_pkg::ADDR_W-1:0]   paddr,
    input  logic [mcct_pkg::DATA_W-1:0]   pwdata,
    output logic [mcct_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_WIDTH-1:0]        first_x,
    input  logic [COORD_WIDTH-1:0]        first_y,
    input  logic [COORD_WIDTH-1:0]        first_vx,
    input  logic [COORD_WIDTH-1:0]        first_vy,
    input  logic [COORD_WIDTH-1:0]        second_x,
    input  logic [COORD_WIDTH-1:0]        second_y,
    input  logic [COORD_WIDTH-1:0]        second_vx,
    input  logic [COORD_WIDTH-1:0]        second_vy,
    input  logic [mcct_pkg::RADIUS_W-1:0] first_radius,
    input  logic [mcct_pkg::RADIUS_W-1:0] second_radius,
    output logic                          done,
    output logic                          will_collide,
    output logic [mcct_pkg::TIME_W-1:0]   contact_time
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = (2 * DW + 2 > 46) ? 2 * DW + 2 : 46;
    localparam int RW = PW + FRACTION_BITS;
    localparam int TW = mcct_pkg::TIME_W;
    localparam int SW = 2 * PW;

    // configuration registers
    logic [mcct_pkg::RADIUS_W-1:0] margin_reg;
    logic [mcct_pkg::LIMIT_W-1:0]  still_reg;
    logic [mcct_pkg::LIMIT_W-1:0]  overlap_reg;
    logic                          cfg_write;
    logic [1:0]                    cfg_index;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg  <= mcct_pkg::MARGIN_RST;
            still_reg   <= mcct_pkg::STILL_RST;
            overlap_reg <= mcct_pkg::OVERLAP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mcct_pkg::REG_MARGIN:  margin_reg  <= pwdata[mcct_pkg::RADIUS_W-1:0];
                mcct_pkg::REG_STILL:   still_reg   <= pwdata[mcct_pkg::LIMIT_W-1:0];
                mcct_pkg::REG_OVERLAP: overlap_reg <= pwdata[mcct_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_index)
            mcct_pkg::REG_MARGIN:  prdata = mcct_pkg::DATA_W'(margin_reg);
            mcct_pkg::REG_STILL:   prdata = mcct_pkg::DATA_W'(still_reg);
            mcct_pkg::REG_OVERLAP: prdata = mcct_pkg::DATA_W'(overlap_reg);
            default:               prdata = '0;
        endcase
    end

    // quadratic and discriminant
    mcct_pkg::ctl_t front_ctl;
    logic [2*PW-1:0] front_d;
    logic [PW-1:0]   front_uh, front_a;

    mcct_front #(
        .COORD_WIDTH(COORD_WIDTH),
        .DW(DW),
        .PW(PW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(start && !busy),
        .first_x(first_x),
        .first_y(first_y),
        .first_vx(first_vx),
        .first_vy(first_vy),
        .second_x(second_x),
        .second_y(second_y),
        .second_vx(second_vx),
        .second_vy(second_vy),
        .first_radius(first_radius),
        .second_radius(second_radius),
        .margin_radius(margin_reg),
        .still_speed_limit(still_reg),
        .overlap_limit(overlap_reg),
        .ctl_out(front_ctl),
        .d_out(front_d),
        .uh_out(front_uh),
        .a_out(front_a)
    );

    // square root chain, one bit per cell
    mcct_pkg::ctl_t  sq_ctl  [0:PW];
    logic [2*PW-1:0] sq_d    [0:PW];
    logic [PW:0]     sq_rem  [0:PW];
    logic [PW-1:0]   sq_root [0:PW];
    logic [SW-1:0]   sq_side [0:PW];

    assign sq_ctl[0]  = front_ctl;
    assign sq_d[0]    = front_d;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = {front_uh, front_a};

    for (genvar i = 0; i < PW; i++)
    begin : g_sqrt
        mcct_sqrt_cell #(
            .PW(PW),
            .SIDE_W(SW)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctl_in(sq_ctl[i]),
            .d_in(sq_d[i]),
            .rem_in(sq_rem[i]),
            .root_in(sq_root[i]),
            .side_in(sq_side[i]),
            .ctl_out(sq_ctl[i+1]),
            .d_out(sq_d[i+1]),
            .rem_out(sq_rem[i+1]),
            .root_out(sq_root[i+1]),
            .side_out(sq_side[i+1])
        );
    end

    // numerator and overflow check
    logic [PW-1:0]  sq_uh, sq_a;
    mcct_pkg::ctl_t num_ctl_reg, sat_ctl_reg;
    logic [PW-1:0]  num_reg, num_a_reg, sat_a_reg;
    logic [RW-1:0]  sat_rem_reg;
    logic           sat_flag;

    assign sq_uh    = sq_side[PW][SW-1:PW];
    assign sq_a     = sq_side[PW][PW-1:0];
    assign sat_flag = (PW + TW)'(num_reg) >= ((PW + TW)'(num_a_reg) << (TW - FRACTION_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ctl_reg <= '0;
            sat_ctl_reg <= '0;
        end
        else
        begin
            num_ctl_reg <= sq_ctl[PW];
            sat_ctl_reg <= '{valid: num_ctl_reg.valid, hit: num_ctl_reg.hit,
                             need_time: num_ctl_reg.need_time, saturate: sat_flag};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= sq_uh - sq_root[PW];
        num_a_reg   <= sq_a;
        sat_rem_reg <= {num_reg, {FRACTION_BITS{1'b0}}};
        sat_a_reg   <= num_a_reg;
    end

    // long division chain, one time bit per cell
    mcct_pkg::ctl_t dv_ctl [0:TW];
    logic [RW-1:0]  dv_rem [0:TW];
    logic [PW-1:0]  dv_a   [0:TW];
    logic [TW-1:0]  dv_q   [0:TW];

    assign dv_ctl[0] = sat_ctl_reg;
    assign dv_rem[0] = sat_rem_reg;
    assign dv_a[0]   = sat_a_reg;
    assign dv_q[0]   = '0;

    for (genvar j = 0; j < TW; j++)
    begin : g_div
        mcct_div_cell #(
            .PW(PW),
            .FRACTION_BITS(FRACTION_BITS),
            .SHIFT(TW - 1 - j)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctl_in(dv_ctl[j]),
            .rem_in(dv_rem[j]),
            .a_in(dv_a[j]),
            .q_in(dv_q[j]),
            .ctl_out(dv_ctl[j+1]),
            .rem_out(dv_rem[j+1]),
            .a_out(dv_a[j+1]),
            .q_out(dv_q[j+1])
        );
    end

    // result register
    logic          done_reg, hit_reg;
    logic [TW-1:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_ctl[TW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= dv_ctl[TW].hit;
        time_reg <= !dv_ctl[TW].need_time ? '0
                  : (dv_ctl[TW].saturate ? '1 : dv_q[TW]);
    end

    assign done         = done_reg;
    assign will_collide = hit_reg;
    assign contact_time = time_reg;

endmodule

@@ design/mcct_front.sv @@
module mcct_front #(
    parameter int COORD_WIDTH = 24,
    parameter int DW = COORD_WIDTH + 1,
    parameter int PW = 52
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [COORD_WIDTH-1:0]        first_x,
    input  logic [COORD_WIDTH-1:0]        first_y,
    input  logic [COORD_WIDTH-1:0]        first_vx,
    input  logic [COORD_WIDTH-1:0]        first_vy,
    input  logic [COORD_WIDTH-1:0]        second_x,
    input  logic [COORD_WIDTH-1:0]        second_y,
    input  logic [COORD_WIDTH-1:0]        second_vx,
    input  logic [COORD_WIDTH-1:0]        second_vy,
    input  logic [mcct_pkg::RADIUS_W-1:0] first_radius,
    input  logic [mcct_pkg::RADIUS_W-1:0] second_radius,
    input  logic [mcct_pkg::RADIUS_W-1:0] margin_radius,
    input  logic [mcct_pkg::LIMIT_W-1:0]  still_speed_limit,
    input  logic [mcct_pkg::LIMIT_W-1:0]  overlap_limit,
    output mcct_pkg::ctl_t                ctl_out,
    output logic [2*PW-1:0]               d_out,
    output logic [PW-1:0]                 uh_out,
    output logic [PW-1:0]                 a_out
);

    localparam int HW = (PW + 1) / 2;
    localparam int FW = 2 * PW + 2;
    localparam int RW = mcct_pkg::RAD_SUM_W;

    typedef struct packed {
        logic still;
        logic ovl;
        logic h_neg;
        logic h_zero;
        logic c_pos;
        logic c_neg;
    } flag_t;

    logic [7:1] valid_reg;

    // stage 1: relative offset, velocity and touching radius
    logic signed [DW-1:0] tx_reg, ty_reg, vx_reg, vy_reg;
    logic [RW-1:0]        rad_reg;

    // stage 2: products
    logic signed [2*DW-1:0] p_vxvx_reg, p_vyvy_reg, p_vxtx_reg, p_vyty_reg;
    logic signed [2*DW-1:0] p_txtx_reg, p_tyty_reg;
    logic [2*RW-1:0]        p_rr_reg;

    // stage 3: quadratic coefficients
    logic signed [PW-1:0] a_reg, h_reg, c_reg;

    // stage 4: magnitudes and flags
    logic [PW-1:0] uh4_reg, uc4_reg, a4_reg;
    flag_t         f4_reg;
    logic [PW-1:0] uh_abs, uc_abs;

    // stage 5: partial products
    logic [2*HW-1:0] hh_ll_reg, hh_lh_reg, hh_hh_reg;
    logic [2*HW-1:0] ac_ll_reg, ac_lh_reg, ac_hl_reg, ac_hh_reg;
    logic [PW-1:0]   uh5_reg, a5_reg;
    flag_t           f5_reg;
    logic [HW-1:0]   h_lo, h_hi, a_lo, a_hi, c_lo, c_hi;

    // stage 6: full products
    logic [FW-1:0] hh_reg, ac_reg;
    logic [PW-1:0] uh6_reg, a6_reg;
    flag_t         f6_reg;

    // stage 7: discriminant and decision
    logic [FW-1:0] d_next;
    logic          d_neg;
    logic [FW-1:0] d_reg;
    logic [PW-1:0] uh7_reg, a7_reg;
    logic          hit_reg, need_reg;

    assign uh_abs = h_reg[PW-1] ? PW'(-h_reg) : PW'(h_reg);
    assign uc_abs = c_reg[PW-1] ? PW'(-c_reg) : PW'(c_reg);

    assign h_lo = uh4_reg[HW-1:0];
    assign h_hi = HW'(uh4_reg[PW-1:HW]);
    assign a_lo = a4_reg[HW-1:0];
    assign a_hi = HW'(a4_reg[PW-1:HW]);
    assign c_lo = uc4_reg[HW-1:0];
    assign c_hi = HW'(uc4_reg[PW-1:HW]);

    assign d_next = f6_reg.c_neg ? (hh_reg + ac_reg) : (hh_reg - ac_reg);
    assign d_neg  = d_reg[FW-1];

    // item valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[6:1], accept};
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        tx_reg  <= $signed({second_x[COORD_WIDTH-1], second_x})
                 - $signed({first_x[COORD_WIDTH-1], first_x});
        ty_reg  <= $signed({second_y[COORD_WIDTH-1], second_y})
                 - $signed({first_y[COORD_WIDTH-1], first_y});
        vx_reg  <= $signed({second_vx[COORD_WIDTH-1], second_vx})
                 - $signed({first_vx[COORD_WIDTH-1], first_vx});
        vy_reg  <= $signed({second_vy[COORD_WIDTH-1], second_vy})
                 - $signed({first_vy[COORD_WIDTH-1], first_vy});
        rad_reg <= RW'(margin_radius) + RW'(first_radius) + RW'(second_radius);

        p_vxvx_reg <= vx_reg * vx_reg;
        p_vyvy_reg <= vy_reg * vy_reg;
        p_vxtx_reg <= vx_reg * tx_reg;
        p_vyty_reg <= vy_reg * ty_reg;
        p_txtx_reg <= tx_reg * tx_reg;
        p_tyty_reg <= ty_reg * ty_reg;
        p_rr_reg   <= rad_reg * rad_reg;

        a_reg <= PW'(p_vxvx_reg) + PW'(p_vyvy_reg);
        h_reg <= PW'(p_vxtx_reg) + PW'(p_vyty_reg);
        c_reg <= PW'(p_txtx_reg) + PW'(p_tyty_reg) - $signed(PW'(p_rr_reg));

        uh4_reg       <= uh_abs;
        uc4_reg       <= uc_abs;
        a4_reg        <= a_reg;
        f4_reg.still  <= (a_reg == '0) || (PW'(a_reg) < PW'(still_speed_limit));
        f4_reg.ovl    <= c_reg < $signed(PW'(overlap_limit));
        f4_reg.h_neg  <= h_reg[PW-1];
        f4_reg.h_zero <= (h_reg == '0);
        f4_reg.c_pos  <= !c_reg[PW-1] && (c_reg != '0);
        f4_reg.c_neg  <= c_reg[PW-1];

        hh_ll_reg <= h_lo * h_lo;
        hh_lh_reg <= h_lo * h_hi;
        hh_hh_reg <= h_hi * h_hi;
        ac_ll_reg <= a_lo * c_lo;
        ac_lh_reg <= a_lo * c_hi;
        ac_hl_reg <= a_hi * c_lo;
        ac_hh_reg <= a_hi * c_hi;
        uh5_reg   <= uh4_reg;
        a5_reg    <= a4_reg;
        f5_reg    <= f4_reg;

        hh_reg  <= (FW'(hh_hh_reg) << (2 * HW)) + (FW'(hh_lh_reg) << (HW + 1))
                 + FW'(hh_ll_reg);
        ac_reg  <= (FW'(ac_hh_reg) << (2 * HW))
                 + ((FW'(ac_lh_reg) + FW'(ac_hl_reg)) << HW) + FW'(ac_ll_reg);
        uh6_reg <= uh5_reg;
        a6_reg  <= a5_reg;
        f6_reg  <= f5_reg;

        d_reg   <= d_next;
        uh7_reg <= uh6_reg;
        a7_reg  <= a6_reg;
        hit_reg <= f6_reg.still ? f6_reg.ovl
                 : (!d_next[FW-1] && (!f6_reg.c_pos || f6_reg.h_neg || f6_reg.h_zero));
        need_reg <= !f6_reg.still && !d_next[FW-1] && f6_reg.c_pos && f6_reg.h_neg;
    end

    // hand over to the root chain
    always_comb
    begin
        ctl_out.valid     = valid_reg[7];
        ctl_out.hit       = hit_reg && !(need_reg && d_neg);
        ctl_out.need_time = need_reg;
        ctl_out.saturate  = 1'b0;
    end

    assign d_out  = d_reg[2*PW-1:0];
    assign uh_out = uh7_reg;
    assign a_out  = a7_reg;

endmodule

@@ design/mcct_sqrt_cell.sv @@
module mcct_sqrt_cell #(
    parameter int PW = 52,
    parameter int SIDE_W = 104
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mcct_pkg::ctl_t      ctl_in,
    input  logic [2*PW-1:0]     d_in,
    input  logic [PW:0]         rem_in,
    input  logic [PW-1:0]       root_in,
    input  logic [SIDE_W-1:0]   side_in,
    output mcct_pkg::ctl_t      ctl_out,
    output logic [2*PW-1:0]     d_out,
    output logic [PW:0]         rem_out,
    output logic [PW-1:0]       root_out,
    output logic [SIDE_W-1:0]   side_out
);

    logic [PW+2:0] cur, trial;
    logic          ge;
    logic [PW:0]   rem_next;

    mcct_pkg::ctl_t  ctl_reg;
    logic [2*PW-1:0] d_reg;
    logic [PW:0]     rem_reg;
    logic [PW-1:0]   root_reg;
    logic [SIDE_W-1:0] side_reg;

    // one root bit: bring down two bits, try root*4+1
    assign cur      = {rem_in, d_in[2*PW-1 -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (cur >= trial);
    assign rem_next = ge ? (PW+1)'(cur - trial) : (PW+1)'(cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_in << 2;
        rem_reg  <= rem_next;
        root_reg <= {root_in[PW-2:0], ge};
        side_reg <= side_in;
    end

    assign ctl_out  = ctl_reg;
    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

@@ design/mcct_div_cell.sv @@
module mcct_div_cell #(
    parameter int PW = 52,
    parameter int FRACTION_BITS = 16,
    parameter int SHIFT = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mcct_pkg::ctl_t               ctl_in,
    input  logic [PW+FRACTION_BITS-1:0]  rem_in,
    input  logic [PW-1:0]                a_in,
    input  logic [mcct_pkg::TIME_W-1:0]  q_in,
    output mcct_pkg::ctl_t               ctl_out,
    output logic [PW+FRACTION_BITS-1:0]  rem_out,
    output logic [PW-1:0]                a_out,
    output logic [mcct_pkg::TIME_W-1:0]  q_out
);

    localparam int RW = PW + FRACTION_BITS;
    localparam int CW = PW + mcct_pkg::TIME_W;

    logic [CW-1:0] a_shift;
    logic          ge;
    logic [mcct_pkg::TIME_W-1:0] q_next;

    mcct_pkg::ctl_t ctl_reg;
    logic [RW-1:0]  rem_reg;
    logic [PW-1:0]  a_reg;
    logic [mcct_pkg::TIME_W-1:0] q_reg;

    // one quotient bit: subtract the shifted divisor if it fits
    assign a_shift = CW'(a_in) << SHIFT;
    assign ge      = (CW'(rem_in) >= a_shift);

    always_comb
    begin
        q_next        = q_in;
        q_next[SHIFT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= ge ? RW'(CW'(rem_in) - a_shift) : rem_in;
        a_reg   <= a_in;
        q_reg   <= q_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign a_out   = a_reg;
    assign q_out   = q_reg;

endmodule

@@ dv/moving_circle_collision_time_checker.sv @@
`timescale 1ns / 100ps

module moving_circle_collision_time_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcct_pkg::ADDR_W-1:0]     paddr,
    input  logic [mcct_pkg::DATA_W-1:0]     pwdata,
    input  logic                            pready,
    input  logic                            start,
    input  logic                            busy,
    input  logic [23:0]                     first_x,
    input  logic [23:0]                     first_y,
    input  logic [23:0]                     first_vx,
    input  logic [23:0]                     first_vy,
    input  logic [23:0]                     second_x,
    input  logic [23:0]                     second_y,
    input  logic [23:0]                     second_vx,
    input  logic [23:0]                     second_vy,
    input  logic [mcct_pkg::RADIUS_W-1:0]   first_radius,
    input  logic [mcct_pkg::RADIUS_W-1:0]   second_radius,
    input  logic                            done,
    input  logic                            will_collide,
    input  logic [mcct_pkg::TIME_W-1:0]     contact_time,
    output int                              errors,
    output int                              pending
);

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic                        hit;
        logic [mcct_pkg::TIME_W-1:0] when;
    } contact_t;

    // shadow copies of the registers
    logic [mcct_pkg::RADIUS_W-1:0] margin_q;
    logic [mcct_pkg::LIMIT_W-1:0]  still_q;
    logic [mcct_pkg::LIMIT_W-1:0]  overlap_q;

    contact_t contacts_due[$];

    // floor square root of a non-negative value below 2^128
    function automatic wide_t floor_sqrt(input wide_t d);
        wide_t r;
        wide_t cand;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            cand = r | (wide_t'(1) <<< k);
            if (cand * cand <= d)
                r = cand;
        end
        return r;
    endfunction

    // first contact of the two swept circles
    function automatic contact_t first_contact(
        input logic signed [23:0] fx, input logic signed [23:0] fy,
        input logic signed [23:0] fvx, input logic signed [23:0] fvy,
        input logic signed [23:0] sx, input logic signed [23:0] sy,
        input logic signed [23:0] svx, input logic signed [23:0] svy,
        input logic [mcct_pkg::RADIUS_W-1:0] r1, input logic [mcct_pkg::RADIUS_W-1:0] r2);
        wide_t tx, ty, vx, vy, rad, a, h, c, d, num, n, cand, q;
        contact_t res;
        tx = wide_t'(sx) - wide_t'(fx);
        ty = wide_t'(sy) - wide_t'(fy);
        vx = wide_t'(svx) - wide_t'(fvx);
        vy = wide_t'(svy) - wide_t'(fvy);
        rad = wide_t'({1'b0, margin_q}) + wide_t'({1'b0, r1}) + wide_t'({1'b0, r2});
        a = vx * vx + vy * vy;
        h = vx * tx + vy * ty;
        c = tx * tx + ty * ty - rad * rad;
        res.hit = 1'b0;
        res.when = '0;
        if (a == 0 || a < wide_t'({1'b0, still_q})) begin
            // no or slow relative motion (below the still limit): touching only if already overlapping
            res.hit = (c < wide_t'({1'b0, overlap_q}));
        end else begin
            d = h * h - a * c;
            if (d >= 0) begin
                if (c > 0 && h < 0) begin
                    // approaching from outside
                    num = -h - floor_sqrt(d);
                    n = num <<< 16;
                    res.hit = 1'b1;
                    if ((a <<< 32) <= n) begin
                        res.when = '1;
                    end else begin
                        q = '0;
                        for (int k = 31; k >= 0; k--) begin
                            cand = q | (wide_t'(1) <<< k);
                            if (a * cand <= n)
                                q = cand;
                        end
                        res.when = q[mcct_pkg::TIME_W-1:0];
                    end
                end else if (c <= 0 || h <= 0) begin
                    res.hit = 1'b1;
                end
            end
        end
        return res;
    endfunction

    assign pending = contacts_due.size();

    // register writes, predictions and result checks
    always @(posedge clk or negedge rst_n)
    begin
        contact_t exp_c;
        if (!rst_n) begin
            margin_q  <= mcct_pkg::MARGIN_RST;
            still_q   <= mcct_pkg::STILL_RST;
            overlap_q <= mcct_pkg::OVERLAP_RST;
            errors    <= 0;
            contacts_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    mcct_pkg::REG_MARGIN:  margin_q  <= pwdata[mcct_pkg::RADIUS_W-1:0];
                    mcct_pkg::REG_STILL:   still_q   <= pwdata[mcct_pkg::LIMIT_W-1:0];
                    mcct_pkg::REG_OVERLAP: overlap_q <= pwdata[mcct_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                contacts_due.push_back(first_contact(first_x, first_y, first_vx, first_vy,
                    second_x, second_y, second_vx, second_vy, first_radius, second_radius));
            if (done) begin
                if (contacts_due.size() == 0) begin
                    $error("result with no item pending");
                    errors <= errors + 1;
                end else begin
                    exp_c = contacts_due.pop_front();
                    if (will_collide !== exp_c.hit) begin
                        $error("will_collide expected %0d actual %0d", exp_c.hit, will_collide);
                        errors <= errors + 1;
                    end else if (contact_time !== exp_c.when) begin
                        $error("contact_time expected %0d actual %0d", exp_c.when,
                            contact_time);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ dv/moving_circle_collision_time_tb.sv @@
`timescale 1ns / 100ps

module moving_circle_collision_time_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ONE_M = 65536;

    // index past the register list
    localparam logic [1:0] REG_NONE = 2'd3;

    typedef struct {
        int fx, fy, fvx, fvy, sx, sy, svx, svy;
        int r1, r2;
    } pair_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [mcct_pkg::ADDR_W-1:0] paddr;
    logic [mcct_pkg::DATA_W-1:0] pwdata;
    logic [mcct_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic start, busy;
    logic [23:0] first_x, first_y, first_vx, first_vy;
    logic [23:0] second_x, second_y, second_vx, second_vy;
    logic [mcct_pkg::RADIUS_W-1:0] first_radius, second_radius;
    logic done, will_collide;
    logic [mcct_pkg::TIME_W-1:0] contact_time;
    int errors, pending;
    int cycles = 0;
    bit quiet_run;

    moving_circle_collision_time uut (.*);

    moving_circle_collision_time_checker checker_i (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // register write: setup phase, then access phase
    task automatic reg_write(input logic [1:0] idx, input logic [mcct_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // present one item and hold it until taken
    task automatic send_pair(input pair_t p);
        int gap;
        first_x <= 24'(p.fx);
        first_y <= 24'(p.fy);
        first_vx <= 24'(p.fvx);
        first_vy <= 24'(p.fvy);
        second_x <= 24'(p.sx);
        second_y <= 24'(p.sy);
        second_vx <= 24'(p.svx);
        second_vy <= 24'(p.svy);
        first_radius <= mcct_pkg::RADIUS_W'(p.r1);
        second_radius <= mcct_pkg::RADIUS_W'(p.r2);
        start <= 1'b1;
        do @(posedge clk); while (busy);
        gap = quiet_run ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all results, then let the chain drain
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    function automatic int rnd_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int dx, dy, sp;
        case ($urandom_range(0, 5))
            0: begin
                // any field value
                p.fx = $urandom; p.fy = $urandom; p.fvx = $urandom; p.fvy = $urandom;
                p.sx = $urandom; p.sy = $urandom; p.svx = $urandom; p.svy = $urandom;
                p.r1 = $urandom; p.r2 = $urandom;
            end
            1, 2: begin
                // head-on approach in a small area
                p.fx = rnd_signed(8 * ONE_M); p.fy = rnd_signed(8 * ONE_M);
                dx = rnd_signed(16 * ONE_M); dy = rnd_signed(16 * ONE_M);
                p.sx = p.fx + dx; p.sy = p.fy + dy;
                sp = $urandom_range(1, 64);
                p.fvx = dx / sp + rnd_signed(ONE_M / 4);
                p.fvy = dy / sp + rnd_signed(ONE_M / 4);
                p.svx = rnd_signed(ONE_M / 2); p.svy = rnd_signed(ONE_M / 2);
                p.r1 = $urandom_range(0, 2 * ONE_M); p.r2 = $urandom_range(0, 2 * ONE_M);
            end
            3: begin
                // nearly matched velocities
                p.fx = rnd_signed(4 * ONE_M); p.fy = rnd_signed(4 * ONE_M);
                p.sx = rnd_signed(4 * ONE_M); p.sy = rnd_signed(4 * ONE_M);
                p.fvx = rnd_signed(8 * ONE_M); p.fvy = rnd_signed(8 * ONE_M);
                p.svx = p.fvx + rnd_signed(80); p.svy = p.fvy + rnd_signed(80);
                p.r1 = $urandom_range(0, 3 * ONE_M); p.r2 = $urandom_range(0, 3 * ONE_M);
            end
            default: begin
                // small area, any motion
                p.fx = rnd_signed(2 * ONE_M); p.fy = rnd_signed(2 * ONE_M);
                p.sx = rnd_signed(2 * ONE_M); p.sy = rnd_signed(2 * ONE_M);
                p.fvx = rnd_signed(2 * ONE_M); p.fvy = rnd_signed(2 * ONE_M);
                p.svx = rnd_signed(2 * ONE_M); p.svy = rnd_signed(2 * ONE_M);
                p.r1 = $urandom_range(0, ONE_M / 2); p.r2 = $urandom_range(0, ONE_M / 2);
            end
        endcase
        return p;
    endfunction

    task automatic random_items(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                quiet_run = ($urandom_range(0, 3) == 0);
            send_pair(random_pair());
        end
        quiet_run = 1'b0;
    endtask

    // stimulus
    initial
    begin
        pair_t p;
        quiet_run = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        start = 1'b0;
        first_x = '0; first_y = '0; first_vx = '0; first_vy = '0;
        second_x = '0; second_y = '0; second_vx = '0; second_vy = '0;
        first_radius = '0; second_radius = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases at reset settings
        // all extremes, both ways
        p = '{8388607, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608, -8388608,
              1048575, 1048575};
        send_pair(p);
        p = '{-8388608, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 8388607,
              1048575, 0};
        send_pair(p);
        // still and overlapping
        p = '{0, 0, 100, 100, ONE_M / 2, 0, 100, 100, ONE_M, ONE_M};
        send_pair(p);
        // still and apart
        p = '{0, 0, 0, 0, 10 * ONE_M, 0, 0, 0, ONE_M, ONE_M};
        send_pair(p);
        // still, identical centers, zero radii
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(p);
        // approaching from outside
        p = '{0, 0, ONE_M, 0, 10 * ONE_M, 0, -ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // passing by, no real root
        p = '{0, 0, ONE_M, 0, 10 * ONE_M, 5 * ONE_M, -ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // grazing touch
        p = '{0, 0, ONE_M, 0, 10 * ONE_M, 2 * ONE_M, -ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // overlapping while moving
        p = '{0, 0, ONE_M, 0, ONE_M, 0, -ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // moving apart
        p = '{0, 0, -ONE_M, 0, 10 * ONE_M, 0, ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // exactly touching, moving apart
        p = '{0, 0, -ONE_M, 0, 2 * ONE_M, 0, ONE_M, 0, ONE_M, ONE_M};
        send_pair(p);
        // just above the still limit, far away
        p = '{-8388608, 0, 66, 0, 8388607, 0, 0, 0, 0, 0};
        send_pair(p);
        drain();

        // no still limit: saturated time
        reg_write(mcct_pkg::REG_STILL, 64'd0);
        reg_write(mcct_pkg::REG_OVERLAP, 64'd0);
        reg_write(mcct_pkg::REG_MARGIN, 64'd1048575);
        p = '{-8388608, 0, 1, 0, 8388607, 0, 0, 0, 0, 0};
        send_pair(p);
        p = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_pair(p);
        p = '{0, 0, 0, 0, 100 * ONE_M, 0, -ONE_M, 0, 0, 0};
        send_pair(p);
        random_items(150);
        drain();

        // widest limits, register bits above the width
        reg_write(mcct_pkg::REG_MARGIN, {$urandom, $urandom});
        reg_write(mcct_pkg::REG_STILL, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(mcct_pkg::REG_OVERLAP, 64'hFFFF_FFFF_FFFF_FFFF);
        random_items(100);
        drain();

        // random settings
        reg_write(mcct_pkg::REG_MARGIN, 64'($urandom_range(0, ONE_M / 4)));
        reg_write(mcct_pkg::REG_STILL,
            {$urandom_range(0, 255), $urandom} >> $urandom_range(0, 39));
        reg_write(mcct_pkg::REG_OVERLAP,
            {$urandom_range(0, 255), $urandom} >> $urandom_range(0, 39));
        random_items(150);
        drain();

        // back to reset values, plus a write past the register list
        reg_write(mcct_pkg::REG_MARGIN, 64'(mcct_pkg::MARGIN_RST));
        reg_write(mcct_pkg::REG_STILL, 64'(mcct_pkg::STILL_RST));
        reg_write(mcct_pkg::REG_OVERLAP, 64'(mcct_pkg::OVERLAP_RST));
        reg_write(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        random_items(230);
        drain();

        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
